>>> sv/spm_pkg.sv
package spm_pkg;

  localparam int OUT_BITS = 24;

  localparam logic [3:0] REG_LEVEL_DECAY    = 4'd0;
  localparam logic [3:0] REG_HOLD_BLOCKS    = 4'd1;
  localparam logic [3:0] REG_SNAP_THRESHOLD = 4'd2;
  localparam logic [3:0] REG_CLIP_THRESHOLD = 4'd3;

  localparam logic [15:0] LEVEL_DECAY_RESET    = 16'd55640;
  localparam logic [15:0] HOLD_BLOCKS_RESET    = 16'd140;
  localparam logic [23:0] SNAP_THRESHOLD_RESET = 24'd839;
  localparam logic [23:0] CLIP_THRESHOLD_RESET = 24'd8304722;

  // 0.995 in Q0.16, truncated.
  localparam logic [15:0] PEAK_DECAY_Q16 = 16'd65208;

  typedef struct packed {
    logic [15:0] level_decay;
    logic [15:0] hold_blocks;
    logic [23:0] snap_threshold;
    logic [23:0] clip_threshold;
  } meter_cfg_t;

  typedef struct packed {
    logic advance;
    logic last;
  } meter_ctl_t;

endpackage

>>> sv/spm_input_stage.sv
module spm_input_stage import spm_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          last_in_block,
  input  logic                          accept,
  input  logic                          advance,
  output logic                          stage_valid,
  output meter_ctl_t                    ctl,
  output logic [SAMPLE_BITS-1:0]        left_mag,
  output logic [SAMPLE_BITS-1:0]        right_mag
);

  logic [SAMPLE_BITS-1:0] left_abs;
  logic [SAMPLE_BITS-1:0] right_abs;
  logic                   stage_last;

  // The negation of the most negative code is full scale itself when read unsigned.
  assign left_abs  = left_sample[SAMPLE_BITS-1] ?
                     (~SAMPLE_BITS'(left_sample)) + 1'b1 : SAMPLE_BITS'(left_sample);
  assign right_abs = right_sample[SAMPLE_BITS-1] ?
                     (~SAMPLE_BITS'(right_sample)) + 1'b1 : SAMPLE_BITS'(right_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_mag   <= left_abs;
      right_mag  <= right_abs;
      stage_last <= last_in_block;
    end
  end

  assign ctl.advance = advance;
  assign ctl.last    = stage_last;

endmodule

>>> sv/spm_channel.sv
module spm_channel import spm_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  meter_ctl_t             ctl,
  input  meter_cfg_t             cfg,
  input  logic [SAMPLE_BITS-1:0] mag,
  output logic [OUT_BITS-1:0]    level_out,
  output logic [OUT_BITS-1:0]    peak_out,
  output logic                   clip_out
);

  localparam int CW = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS;

  logic [SAMPLE_BITS-1:0]    block_max;
  logic [SAMPLE_BITS-1:0]    level;
  logic [SAMPLE_BITS-1:0]    peak;
  logic [15:0]               hold_count;
  logic                      clip_flag;

  logic [SAMPLE_BITS-1:0]    max_next;
  logic [SAMPLE_BITS+15:0]   level_prod;
  logic [SAMPLE_BITS+15:0]   peak_prod;
  logic [SAMPLE_BITS-1:0]    level_decayed;
  logic [SAMPLE_BITS-1:0]    peak_decayed;
  logic [SAMPLE_BITS-1:0]    level_next;
  logic [SAMPLE_BITS-1:0]    peak_next;
  logic [15:0]               hold_count_next;
  logic                      clip_flag_next;
  logic [CW-1:0]             level_wide;
  logic [CW-1:0]             peak_wide;

  assign max_next = (mag > block_max) ? mag : block_max;

  assign level_prod    = (SAMPLE_BITS + 16)'(level) * (SAMPLE_BITS + 16)'(cfg.level_decay);
  assign peak_prod     = (SAMPLE_BITS + 16)'(peak) * (SAMPLE_BITS + 16)'(PEAK_DECAY_Q16);
  assign level_decayed = level_prod[SAMPLE_BITS+15:16];
  assign peak_decayed  = peak_prod[SAMPLE_BITS+15:16];

  always_comb begin
    level_next      = level;
    peak_next       = peak;
    hold_count_next = hold_count;
    clip_flag_next  = clip_flag;

    if (max_next > level) begin
      level_next = max_next;
    end else if (CW'(level_decayed) < CW'(cfg.snap_threshold)) begin
      level_next = '0;
    end else begin
      level_next = level_decayed;
    end

    if (max_next >= peak) begin
      peak_next       = max_next;
      hold_count_next = cfg.hold_blocks;
    end else if (hold_count != 16'd0) begin
      hold_count_next = hold_count - 16'd1;
    end else if (CW'(peak_decayed) < CW'(cfg.snap_threshold)) begin
      peak_next = '0;
    end else begin
      peak_next = peak_decayed;
    end

    if (CW'(max_next) >= CW'(cfg.clip_threshold)) begin
      clip_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_max  <= '0;
      level      <= '0;
      peak       <= '0;
      hold_count <= '0;
      clip_flag  <= 1'b0;
    end else if (ctl.advance) begin
      if (ctl.last) begin
        block_max  <= '0;
        level      <= level_next;
        peak       <= peak_next;
        hold_count <= hold_count_next;
        clip_flag  <= clip_flag_next;
      end else begin
        block_max <= max_next;
      end
    end
  end

  assign level_wide = CW'(level);
  assign peak_wide  = CW'(peak);
  assign level_out  = level_wide[OUT_BITS-1:0];
  assign peak_out   = peak_wide[OUT_BITS-1:0];
  assign clip_out   = clip_flag;

endmodule

>>> sv/stereo_peak_meter_top.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     left_sample, right_sample, last_in_block
// out      out_valid / out_ready   left/right_level, left/right_peak, left/right_clip
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is accepted per cycle unless a last item waits; meter state updates on advance.
// A result is presented as a block's last item advances, with that update.
// The level and peak state registers serve as the result register.
// A last item waits in the input register while an earlier result is not taken.
// Reset clears the meter state and loads the register defaults; cfg_ready is always high.
module stereo_peak_meter_top import spm_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          last_in_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_BITS-1:0]           left_level,
  output logic [OUT_BITS-1:0]           right_level,
  output logic [OUT_BITS-1:0]           left_peak,
  output logic [OUT_BITS-1:0]           right_peak,
  output logic                          left_clip,
  output logic                          right_clip,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  meter_cfg_t             cfg;
  meter_ctl_t             ctl;
  logic                   stage_valid;
  logic                   advance;
  logic                   slot_free;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] left_mag;
  logic [SAMPLE_BITS-1:0] right_mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_decay    <= LEVEL_DECAY_RESET;
      cfg.hold_blocks    <= HOLD_BLOCKS_RESET;
      cfg.snap_threshold <= SNAP_THRESHOLD_RESET;
      cfg.clip_threshold <= CLIP_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEVEL_DECAY:    cfg.level_decay    <= cfg_data[15:0];
        REG_HOLD_BLOCKS:    cfg.hold_blocks    <= cfg_data[15:0];
        REG_SNAP_THRESHOLD: cfg.snap_threshold <= cfg_data[23:0];
        REG_CLIP_THRESHOLD: cfg.clip_threshold <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign advance   = stage_valid && (!ctl.last || slot_free);
  assign in_ready  = !stage_valid || advance;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  spm_input_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_input (
    .clk          (clk),
    .rst          (rst),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_in_block(last_in_block),
    .accept       (accept),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .ctl          (ctl),
    .left_mag     (left_mag),
    .right_mag    (right_mag)
  );

  spm_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg      (cfg),
    .mag      (left_mag),
    .level_out(left_level),
    .peak_out (left_peak),
    .clip_out (left_clip)
  );

  spm_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg      (cfg),
    .mag      (right_mag),
    .level_out(right_level),
    .peak_out (right_peak),
    .clip_out (right_clip)
  );

  a_clip_sticky: assert property (@(posedge clk) disable iff (rst)
    (left_clip || right_clip) |=> ((left_clip || !$past(left_clip)) &&
                                   (right_clip || !$past(right_clip))))
    else $error("clip flag cleared without reset");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && ctl.last && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a block end is blocked");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid && ctl.last))
    else $error("result raised without a block end");

  a_no_update_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(left_level) && $stable(right_peak)))
    else $error("meter state changed under a pending result");

endmodule

>>> bench/stereo_peak_meter_top_test.sv
module stereo_peak_meter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spm_pkg::*;

  localparam int NUM_ROWS = 14;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [23:0] FULL_SCALE = 24'h800000;
  localparam logic [15:0] PEAK_DECAY = PEAK_DECAY_Q16;

  typedef struct packed {
    logic [23:0] left_level;
    logic [23:0] right_level;
    logic [23:0] left_peak;
    logic [23:0] right_peak;
    logic        left_clip;
    logic        right_clip;
  } meter_result_t;

  typedef struct packed {
    logic [23:0] block_max;
    logic [23:0] level;
    logic [23:0] peak;
    logic [15:0] hold;
    logic        clip;
  } channel_meter_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               fin;
    logic               typed;
    meter_result_t      want;
  } sample_row_t;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_QUIET, MIX_EDGE} sample_mix_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] left_sample;
  logic signed [23:0] right_sample;
  logic               last_in_block;
  logic               out_valid;
  logic               out_ready;
  logic [23:0]        left_level;
  logic [23:0]        right_level;
  logic [23:0]        left_peak;
  logic [23:0]        right_peak;
  logic               left_clip;
  logic               right_clip;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         cfg_index;
  logic [31:0]        cfg_data;

  logic               typed_check;
  meter_result_t      typed_want;

  meter_cfg_t         meter_cfg;
  channel_meter_t     left_meter;
  channel_meter_t     right_meter;
  meter_result_t      results_due[$];
  sample_row_t        directed_rows [NUM_ROWS];
  meter_cfg_t         phase_cfg [NUM_PHASES];

  int mismatches = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int settings_used = 1;
  bit send_burst = 0;
  bit take_burst = 0;

  stereo_peak_meter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_in_block(last_in_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_level   (left_level),
    .right_level  (right_level),
    .left_peak    (left_peak),
    .right_peak   (right_peak),
    .left_clip    (left_clip),
    .right_clip   (right_clip),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [23:0] sample_magnitude(logic [23:0] s);
    return s[23] ? (~s + 24'd1) : s;
  endfunction

  function automatic logic [23:0] scale_q16(logic [23:0] v, logic [15:0] f);
    logic [39:0] p;
    p = {16'd0, v} * {24'd0, f};
    return p[39:16];
  endfunction

  function automatic channel_meter_t close_block(channel_meter_t c);
    logic [23:0] m;
    logic [23:0] nv;
    m = c.block_max;
    if (m > c.level) begin
      c.level = m;
    end else begin
      nv = scale_q16(c.level, meter_cfg.level_decay);
      c.level = (nv < meter_cfg.snap_threshold) ? 24'd0 : nv;
    end
    if (m >= c.peak) begin
      c.peak = m;
      c.hold = meter_cfg.hold_blocks;
    end else if (c.hold != 16'd0) begin
      c.hold = c.hold - 16'd1;
    end else begin
      nv = scale_q16(c.peak, PEAK_DECAY);
      c.peak = (nv < meter_cfg.snap_threshold) ? 24'd0 : nv;
    end
    if (m >= meter_cfg.clip_threshold) begin
      c.clip = 1'b1;
    end
    c.block_max = 24'd0;
    return c;
  endfunction

  function automatic logic [23:0] with_sign(logic [23:0] mag);
    if (mag >= FULL_SCALE) begin
      return FULL_SCALE;
    end
    return $urandom_range(0, 1) ? (~mag + 24'd1) : mag;
  endfunction

  function automatic logic [23:0] draw_sample(sample_mix_t mix, channel_meter_t c);
    logic [23:0] mag;
    case (mix)
      MIX_FULL: begin
        return 24'($urandom());
      end
      MIX_SMALL: begin
        return with_sign(24'($urandom_range(0, 4000)));
      end
      MIX_QUIET: begin
        return with_sign(24'($urandom_range(0, 3)));
      end
      default: begin
        case ($urandom_range(0, 5))
          0: mag = FULL_SCALE;
          1: mag = 24'h7FFFFF;
          2: mag = (meter_cfg.clip_threshold == 24'd0) ? 24'd0 :
                   meter_cfg.clip_threshold - 24'($urandom_range(0, 1));
          3: mag = c.peak;
          4: mag = c.level;
          default: mag = meter_cfg.snap_threshold + 24'($urandom_range(0, 1));
        endcase
        return with_sign(mag);
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    meter_result_t due;
    meter_result_t res;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVEL_DECAY:    meter_cfg.level_decay = cfg_data[15:0];
          REG_HOLD_BLOCKS:    meter_cfg.hold_blocks = cfg_data[15:0];
          REG_SNAP_THRESHOLD: meter_cfg.snap_threshold = cfg_data[23:0];
          REG_CLIP_THRESHOLD: meter_cfg.clip_threshold = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result arrived with none expected");
          mismatches++;
        end else begin
          due = results_due.pop_front();
          check_field("left_level", due.left_level, left_level);
          check_field("right_level", due.right_level, right_level);
          check_field("left_peak", due.left_peak, left_peak);
          check_field("right_peak", due.right_peak, right_peak);
          check_field("left_clip", 24'(due.left_clip), 24'(left_clip));
          check_field("right_clip", 24'(due.right_clip), 24'(right_clip));
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        samples_taken++;
        if (sample_magnitude(left_sample) > left_meter.block_max) begin
          left_meter.block_max = sample_magnitude(left_sample);
        end
        if (sample_magnitude(right_sample) > right_meter.block_max) begin
          right_meter.block_max = sample_magnitude(right_sample);
        end
        if (last_in_block) begin
          left_meter = close_block(left_meter);
          right_meter = close_block(right_meter);
          res = '{left_meter.level, right_meter.level, left_meter.peak, right_meter.peak,
                  left_meter.clip, right_meter.clip};
          results_due.push_back(typed_check ? typed_want : res);
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        take_burst = !take_burst;
      end
      stall = take_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_sample(input logic [23:0] l, input logic [23:0] r, input logic fin,
                             input logic typed, input meter_result_t want);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      send_burst = !send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    last_in_block <= fin;
    typed_check <= typed;
    typed_want <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [23:0] v);
    logic [31:0] data;
    data = $urandom();
    if (idx == REG_LEVEL_DECAY || idx == REG_HOLD_BLOCKS) begin
      data[15:0] = v[15:0];
    end else begin
      data[23:0] = v;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  initial begin : stimulus
    int p;
    int i;
    int len;
    int sent;
    logic fin;
    sample_mix_t left_mix;
    sample_mix_t right_mix;

    meter_cfg = '{LEVEL_DECAY_RESET, HOLD_BLOCKS_RESET, SNAP_THRESHOLD_RESET,
                  CLIP_THRESHOLD_RESET};
    left_meter = '0;
    right_meter = '0;
    directed_rows = '{
      '{0, 0, 1, 1, '{0, 0, 0, 0, 0, 0}},
      '{10, -1, 1, 1, '{10, 1, 10, 1, 0, 0}},
      '{-8388608, 8304721, 1, 1, '{8388608, 8304721, 8388608, 8304721, 1, 0}},
      '{100, -100, 0, 0, '0},
      '{-5, 5, 1, 0, '0},
      '{5592405, -5592406, 0, 0, '0},
      '{-1, 1, 1, 0, '0},
      '{8388607, -8388607, 1, 0, '0},
      '{1, 1, 0, 0, '0},
      '{-8388607, 0, 1, 0, '0},
      '{0, 0, 1, 0, '0},
      '{0, 0, 1, 0, '0},
      '{3, -3, 0, 0, '0},
      '{-2, 8304720, 1, 0, '0}
    };
    phase_cfg = '{
      '{16'd65535, 16'd65535, 24'd8388608, 24'd8388608},
      '{16'd40000, 16'd3, 24'd2000, 24'd6000000},
      '{16'd0, 16'd0, 24'd0, 24'd0},
      '{16'd60000, 16'd1, 24'd100, 24'd8000000},
      '{16'd20000, 16'd10, 24'd839, 24'd8304722},
      '{16'd65000, 16'd0, 24'd1, 24'd8388607}
    };

    rst <= 1'b1;
    in_valid <= 1'b0;
    left_sample <= '0;
    right_sample <= '0;
    last_in_block <= 1'b0;
    typed_check <= 1'b0;
    typed_want <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_LEVEL_DECAY;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_ROWS; i++) begin
      send_sample(directed_rows[i].left, directed_rows[i].right, directed_rows[i].fin,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(REG_LEVEL_DECAY, {8'd0, phase_cfg[p].level_decay});
      write_reg(REG_HOLD_BLOCKS, {8'd0, phase_cfg[p].hold_blocks});
      write_reg(REG_SNAP_THRESHOLD, phase_cfg[p].snap_threshold);
      write_reg(REG_CLIP_THRESHOLD, phase_cfg[p].clip_threshold);
      if (p % 2 == 1) begin
        write_reg(4'($urandom_range(int'(REG_CLIP_THRESHOLD) + 1, 15)), 24'($urandom()));
      end
      cfg_valid <= 1'b0;
      settings_used++;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        left_mix = sample_mix_t'($urandom_range(0, 3));
        right_mix = sample_mix_t'($urandom_range(0, 3));
        for (i = 0; i < len && sent < ITEMS_PER_PHASE; i++) begin
          fin = (i == len - 1) || (sent + 1 == ITEMS_PER_PHASE);
          send_sample(draw_sample(left_mix, left_meter), draw_sample(right_mix, right_meter),
                      fin, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d samples and %0d block results over %0d register settings.",
             samples_taken, results_checked, settings_used);
    if (mismatches == 0) begin
      $display("stereo_peak_meter_top_test: PASS");
    end else begin
      $display("stereo_peak_meter_top_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Run timed out with %0d results outstanding.", results_due.size());
    $display("stereo_peak_meter_top_test: FAIL");
    $finish;
  end

endmodule
